[rtl/ppd_pkg.sv]
// package: widths, defaults and register codes of the peak preserving decimator
`default_nettype none
package ppd_pkg;
   localparam int IN_MAX_DEFAULT  = 256;
   localparam int OUT_MAX_DEFAULT = 64;
   localparam int X_SPAN_DEFAULT  = 100;
   localparam int SAMPLE_W = 16;
   localparam int XPOS_W   = 13;
   localparam int INLEN_W  = 9;
   localparam int OUTLEN_W = 7;
   localparam logic [0:0] REG_IN_LEN  = 1'b0;
   localparam logic [0:0] REG_OUT_LEN = 1'b1;
endpackage
`default_nettype wire

[rtl/ppd_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module ppd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/ppd_front.sv]
// front end: loads samples, keeps sum and count, hands closed frames to the queue
`default_nettype none
module ppd_front import ppd_pkg::*; #(
   parameter int IN_MAX = IN_MAX_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [SAMPLE_W-1:0]       req_sample,
   input  wire logic [INLEN_W-1:0]        in_len,
   input  wire logic                      back_busy,
   output logic                           st_wr_en,
   output logic [$clog2(IN_MAX)-1:0]      st_wr_addr,
   output logic [SAMPLE_W-1:0]            st_wr_data,
   output logic                           frm_valid,
   output logic [SAMPLE_W+$clog2(IN_MAX+1)-1:0] frm_sum,
   output logic [$clog2(IN_MAX+1)-1:0]    frm_n
);
   localparam int AW = $clog2(IN_MAX);
   localparam int CW = $clog2(IN_MAX+1);
   localparam int SW = SAMPLE_W + CW;
   localparam int LW = (INLEN_W > CW) ? INLEN_W : CW;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_new;
   logic [SW-1:0] sum_ff, sum_in, sum_new;
   logic [AW-1:0] addr;
   logic [LW-1:0] eff_len, lim;
   logic          accept, close;

   assign req_stall = back_busy;
   assign accept    = req_valid && !req_stall;
   assign addr      = (cnt_ff >= CW'(IN_MAX)) ? AW'(IN_MAX-1) : cnt_ff[AW-1:0];
   assign cnt_new   = CW'({1'b0, addr}) + CW'(1);
   assign sum_new   = sum_ff + SW'(req_sample);
   assign lim       = LW'(in_len);
   always_comb begin
      eff_len = lim;
      if (lim == '0) eff_len = LW'(1);
      else if (lim > LW'(IN_MAX)) eff_len = LW'(IN_MAX);
   end
   assign close = LW'(cnt_new) >= eff_len;
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (accept) begin
         cnt_in = close ? '0 : cnt_new;
         sum_in = close ? '0 : sum_new;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
   end
   assign st_wr_en   = accept;
   assign st_wr_addr = addr;
   assign st_wr_data = req_sample;
   assign frm_valid  = accept && close;
   assign frm_sum    = sum_new;
   assign frm_n      = cnt_new;
endmodule
`default_nettype wire

[rtl/ppd_back.sv]
// back end: mean division, peak scan, point store fill and point emission
`default_nettype none
module ppd_back import ppd_pkg::*; #(
   parameter int IN_MAX  = IN_MAX_DEFAULT,
   parameter int OUT_MAX = OUT_MAX_DEFAULT,
   parameter int X_SPAN  = X_SPAN_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      frm_valid,
   input  wire logic [SAMPLE_W+$clog2(IN_MAX+1)-1:0] frm_sum,
   input  wire logic [$clog2(IN_MAX+1)-1:0] frm_n,
   input  wire logic [OUTLEN_W-1:0]       out_len,
   output logic                           busy,
   output logic [$clog2(IN_MAX)-1:0]      st_rd_addr,
   input  wire logic [SAMPLE_W-1:0]       st_rd_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [XPOS_W-1:0]              rsp_x_position,
   output logic [SAMPLE_W-1:0]            rsp_y_value,
   output logic                           rsp_last_point
);
   localparam int AW  = $clog2(IN_MAX);
   localparam int CW  = $clog2(IN_MAX+1);
   localparam int SW  = SAMPLE_W + CW;
   localparam int PW  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
   localparam int MW  = $clog2(OUT_MAX+1);
   localparam int NW  = CW + MW + 2;
   localparam int STW = $clog2(X_SPAN+1);
   localparam int RW  = 2*STW + MW + 1;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DIV = 6'b000010, S_CLR = 6'b000100,
      S_SCAN = 6'b001000, S_MAP = 6'b010000, S_EMIT = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [SW-1:0]  quo_ff, quo_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [$clog2(SW+1)-1:0] bit_ff, bit_in;
   logic [MW-1:0]  m_ff, m_in;
   logic [STW-1:0] step_ff, step_in;
   logic [RW-1:0]  srem_ff, srem_in;
   logic [CW-1:0]  p_ff, p_in;
   logic [SAMPLE_W-1:0] w1_ff, w1_in, w2_ff, w2_in;
   logic [1:0]     fill_ff, fill_in;
   logic [NW-1:0]  num_ff, num_in, idx_ff, idx_in;
   logic [SAMPLE_W-1:0] pv_ff, pv_in;
   logic [OUT_MAX-1:0]  claim_ff, claim_in;
   logic [PW-1:0]  k_ff, k_in;
   logic [XPOS_W-1:0] x_ff, x_in;
   logic           ov_ff, ov_in;
   logic [XPOS_W-1:0] ox_ff, ox_in;
   logic [SAMPLE_W-1:0] oy_ff, oy_in;
   logic           ol_ff, ol_in;
   logic           pw_en;
   logic [PW-1:0]  pw_addr, pr_addr;
   logic [SAMPLE_W-1:0] pw_data, pr_data;
   logic [SW:0]    trial;
   logic [MW-1:0]  m_eff;
   logic [NW-1:0]  den2;
   logic [NW:0]    ntrial;
   logic           is_peak, out_free, rd_pend_ff, rd_pend_in;

   assign m_eff = (out_len == '0) ? MW'(1) :
                  (OUTLEN_W'(out_len) > OUTLEN_W'(OUT_MAX)) ? MW'(OUT_MAX) : MW'(out_len);
   assign trial    = {rem_ff, quo_ff[SW-1]} - {1'b0, SW'(n_ff)};
   assign den2     = NW'(n_ff) << 1;
   assign ntrial   = {1'b0, num_ff} - {1'b0, den2};
   assign is_peak  = (w2_ff > quo_ff[SAMPLE_W-1:0]) && (quo_ff[SW-1:SAMPLE_W] == '0)
                     && (w2_ff >= w1_ff) && (w2_ff >= st_rd_data);
   assign out_free = !ov_ff || !rsp_stall;
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff; rem_in = rem_ff; quo_in = quo_ff; n_in = n_ff;
      bit_in = bit_ff; m_in = m_ff; step_in = step_ff; srem_in = srem_ff;
      p_in = p_ff; w1_in = w1_ff; w2_in = w2_ff; fill_in = fill_ff;
      num_in = num_ff; idx_in = idx_ff; pv_in = pv_ff; claim_in = claim_ff;
      k_in = k_ff; x_in = x_ff; ov_in = ov_ff; ox_in = ox_ff; oy_in = oy_ff;
      ol_in = ol_ff; rd_pend_in = 1'b0;
      pw_en = 1'b0; pw_addr = k_ff; pw_data = quo_ff[SAMPLE_W-1:0];
      pr_addr = k_ff;
      st_rd_addr = p_ff[AW-1:0];
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (frm_valid) begin
               state_in = S_DIV; quo_in = frm_sum; rem_in = '0; n_in = frm_n;
               bit_in = ($clog2(SW+1))'(SW); m_in = m_eff;
               srem_in = RW'(X_SPAN); step_in = '0;
            end
         end
         S_DIV: begin
            // restoring divider for the mean, with step = X_SPAN / m by repeated subtraction alongside
            if (bit_ff != '0) begin
               if (!trial[SW]) begin
                  rem_in = trial[SW-1:0]; quo_in = {quo_ff[SW-2:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[SW-2:0], quo_ff[SW-1]}; quo_in = {quo_ff[SW-2:0], 1'b0};
               end
               bit_in = bit_ff - 1'b1;
            end
            if (srem_ff >= RW'(m_ff)) begin
               srem_in = srem_ff - RW'(m_ff); step_in = step_ff + 1'b1;
            end
            if (bit_ff == '0 && srem_ff < RW'(m_ff)) begin
               state_in = S_CLR; k_in = '0; claim_in = '0;
            end
         end
         S_CLR: begin
            pw_en = 1'b1;
            k_in = k_ff + 1'b1;
            if (MW'(k_ff) == m_ff - 1'b1) begin
               state_in = S_SCAN; p_in = '0; fill_in = '0;
            end
         end
         S_SCAN: begin
            // sample window through the ram read latency
            if (rd_pend_ff) begin
               w1_in = w2_ff; w2_in = st_rd_data;
               if (fill_ff != 2'd2) fill_in = fill_ff + 1'b1;
            end
            if (rd_pend_ff && fill_ff == 2'd2 && is_peak) begin
               state_in = S_MAP; pv_in = w2_ff;
               num_in = NW'(p_ff - CW'(2)) * NW'(m_ff) * NW'(2) + NW'(n_ff);
               idx_in = '0;
               rd_pend_in = 1'b0;
            end else if (rd_pend_ff && p_ff == n_ff && !(fill_ff != 2'd2)) begin
               state_in = S_EMIT; k_in = '0; x_in = '0; rd_pend_in = 1'b0;
            end else if (p_ff < n_ff && !(rd_pend_ff && fill_ff == 2'd2 && is_peak)) begin
               rd_pend_in = 1'b1; p_in = p_ff + 1'b1;
            end else if (p_ff >= n_ff && !rd_pend_ff) begin
               state_in = S_EMIT; k_in = '0; x_in = '0;
            end
         end
         S_MAP: begin
            // index = (2pm+n)/(2n) by repeated subtraction
            if (!ntrial[NW]) begin
               num_in = ntrial[NW-1:0]; idx_in = idx_ff + 1'b1;
            end else begin
               if (idx_ff > NW'(m_ff - 1'b1)) begin
                  pw_addr = PW'(m_ff - 1'b1);
               end else begin
                  pw_addr = idx_ff[PW-1:0];
               end
               if (!claim_ff[pw_addr]) begin
                  pw_en = 1'b1; pw_data = pv_ff; claim_in[pw_addr] = 1'b1;
               end
               state_in = S_SCAN;
               if (p_ff >= n_ff) begin
                  state_in = S_EMIT; k_in = '0; x_in = '0;
               end else begin
                  rd_pend_in = 1'b1; p_in = p_ff + 1'b1;
               end
            end
         end
         S_EMIT: begin
            pr_addr = k_ff;
            if (rd_pend_ff && out_free) begin
               ov_in = 1'b1; ox_in = x_ff; oy_in = pr_data;
               ol_in = (MW'(k_ff) == m_ff - 1'b1);
               x_in = x_ff + XPOS_W'(step_ff);
               if (MW'(k_ff) == m_ff - 1'b1) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1; pr_addr = k_ff + 1'b1; rd_pend_in = 1'b1;
               end
            end else if (!rd_pend_ff) begin
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ov_ff <= 1'b0; rd_pend_ff <= 1'b0; claim_ff <= '0;
      end else begin
         state_ff <= state_in; ov_ff <= ov_in; rd_pend_ff <= rd_pend_in;
         claim_ff <= claim_in;
      end
   end
   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; n_ff <= n_in; bit_ff <= bit_in;
      m_ff <= m_in; step_ff <= step_in; srem_ff <= srem_in; p_ff <= p_in;
      w1_ff <= w1_in; w2_ff <= w2_in; fill_ff <= fill_in;
      num_ff <= num_in; idx_ff <= idx_in; pv_ff <= pv_in; k_ff <= k_in;
      x_ff <= x_in; ox_ff <= ox_in; oy_ff <= oy_in; ol_ff <= ol_in;
   end

   ppd_ram #(.WIDTH(SAMPLE_W), .DEPTH(OUT_MAX > 1 ? OUT_MAX : 2)) u_points (
      .clock(clock), .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(pr_addr), .rd_data(pr_data)
   );

   assign rsp_valid      = ov_ff;
   assign rsp_x_position = ox_ff;
   assign rsp_y_value    = oy_ff;
   assign rsp_last_point = ol_ff;
endmodule
`default_nettype wire

[rtl/ppd_queue.sv]
// frame descriptor queue between front and back end
`default_nettype none
module ppd_queue #(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [W-1:0] in_data,
   input  wire logic         out_take,
   output logic              out_valid,
   output logic [W-1:0]      out_data,
   output logic              full
);
   logic         v_ff, v_in;
   logic [W-1:0] d_ff, d_in;
   always_comb begin
      v_in = v_ff; d_in = d_ff;
      if (out_take) v_in = 1'b0;
      if (in_valid) begin v_in = 1'b1; d_in = in_data; end
   end
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else v_ff <= v_in;
      d_ff <= d_in;
   end
   assign out_valid = v_ff;
   assign out_data  = d_ff;
   assign full      = v_ff;
endmodule
`default_nettype wire

[rtl/peak_preserving_decimator_top.sv]
// top level of the peak preserving decimator
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/stall    | req_sample[15:0]
//  rsp     | out | rsp_valid/stall    | rsp_x_position, rsp_y_value, rsp_last_point
//  csr     | in  | apb psel/penable   | in_len @0, out_len @4
// a sample is taken while the back end is idle and the frame queue is empty
// a closed frame goes through the mean and step division, the point store clear, the sample scan
// with an index mapping step for each peak, then point emission
// req_stall is high after the closing sample till the last point enters the output register
// synchronous reset restores in_len 256 and out_len 64 and drops all transactions
`default_nettype none
module peak_preserving_decimator_top import ppd_pkg::*; #(
   parameter int IN_MAX  = IN_MAX_DEFAULT,
   parameter int OUT_MAX = OUT_MAX_DEFAULT,
   parameter int X_SPAN  = X_SPAN_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [XPOS_W-1:0]        rsp_x_position,
   output logic [SAMPLE_W-1:0]      rsp_y_value,
   output logic                     rsp_last_point,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   localparam int AW = $clog2(IN_MAX);
   localparam int CW = $clog2(IN_MAX+1);
   localparam int SW = SAMPLE_W + CW;
   logic [INLEN_W-1:0]  in_len_ff;
   logic [OUTLEN_W-1:0] out_len_ff;
   logic                wr, st_wr_en, frm_valid, q_valid, q_full, back_busy, fstall;
   logic [AW-1:0]       st_wr_addr, st_rd_addr;
   logic [SAMPLE_W-1:0] st_wr_data, st_rd_data;
   logic [SW-1:0]       frm_sum, q_sum;
   logic [CW-1:0]       frm_n, q_n;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_len_ff <= INLEN_W'(256); out_len_ff <= OUTLEN_W'(64);
      end else if (wr && paddr[2] == REG_IN_LEN && paddr[1:0] == 2'b00) begin
         in_len_ff <= pwdata[INLEN_W-1:0];
      end else if (wr && paddr[2] == REG_OUT_LEN && paddr[1:0] == 2'b00) begin
         out_len_ff <= pwdata[OUTLEN_W-1:0];
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_IN_LEN) prdata = 32'(in_len_ff);
      else prdata = 32'(out_len_ff);
   end

   assign fstall = back_busy || q_full;
   ppd_front #(.IN_MAX(IN_MAX)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_sample(req_sample), .in_len(in_len_ff), .back_busy(fstall),
      .st_wr_en(st_wr_en), .st_wr_addr(st_wr_addr), .st_wr_data(st_wr_data),
      .frm_valid(frm_valid), .frm_sum(frm_sum), .frm_n(frm_n)
   );
   ppd_ram #(.WIDTH(SAMPLE_W), .DEPTH(1 << AW)) u_samples (
      .clock(clock), .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_data),
      .rd_addr(st_rd_addr), .rd_data(st_rd_data)
   );
   ppd_queue #(.W(SW+CW)) u_queue (
      .clock(clock), .reset(reset), .in_valid(frm_valid), .in_data({frm_sum, frm_n}),
      .out_take(q_valid && !back_busy), .out_valid(q_valid), .out_data({q_sum, q_n}),
      .full(q_full)
   );
   ppd_back #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX), .X_SPAN(X_SPAN)) u_back (
      .clock(clock), .reset(reset), .frm_valid(q_valid && !back_busy), .frm_sum(q_sum),
      .frm_n(q_n), .out_len(out_len_ff), .busy(back_busy), .st_rd_addr(st_rd_addr),
      .st_rd_data(st_rd_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_x_position(rsp_x_position), .rsp_y_value(rsp_y_value),
      .rsp_last_point(rsp_last_point)
   );

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      back_busy |-> req_stall) else $error("sample taken during frame work");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_y_value))
      else $error("stalled point changed");
   a_queue_single: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !frm_valid) else $error("frame queue overrun");
endmodule
`default_nettype wire

[tb/peak_preserving_decimator_checker.sv]
// checker: predicts decimated frames from accepted samples and compares each result transaction
`default_nettype none
module peak_preserving_decimator_checker import ppd_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [XPOS_W-1:0]   rsp_x_position,
   input  wire logic [SAMPLE_W-1:0] rsp_y_value,
   input  wire logic                rsp_last_point,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   input  wire logic                pready,
   output int                       failures,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [XPOS_W-1:0]   x;
      logic [SAMPLE_W-1:0] y;
      logic                last;
   } point_type;

   point_type expected_points[$];
   logic [SAMPLE_W-1:0] frame_samples[IN_MAX_DEFAULT];
   longint unsigned frame_sum;
   int unsigned held;
   logic [INLEN_W-1:0] in_len_reg;
   logic [OUTLEN_W-1:0] out_len_reg;

   assign pending = expected_points.size();

   function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic decimate_frame(int unsigned n);
      int unsigned m;
      longint unsigned mean, idx, v, span;
      logic [SAMPLE_W-1:0] pts[OUT_MAX_DEFAULT];
      bit claimed[OUT_MAX_DEFAULT];
      point_type pt;
      m = clamp_len(out_len_reg, OUT_MAX_DEFAULT);
      mean = frame_sum / n;
      span = X_SPAN_DEFAULT / m;
      for (int k = 0; k < m; k++) begin
         pts[k] = mean[SAMPLE_W-1:0];
         claimed[k] = 0;
      end
      for (int p = 1; p + 1 < n; p++) begin
         v = frame_samples[p];
         if (v > mean && v >= frame_samples[p-1] && v >= frame_samples[p+1]) begin
            idx = (2 * longint'(p) * m + n) / (2 * longint'(n));
            if (idx > m - 1) idx = m - 1;
            if (!claimed[idx]) begin
               claimed[idx] = 1;
               pts[idx] = v[SAMPLE_W-1:0];
            end
         end
      end
      for (int k = 0; k < m; k++) begin
         pt.x = XPOS_W'(k * span);
         pt.y = pts[k];
         pt.last = (k + 1 == m);
         expected_points.push_back(pt);
      end
      frame_sum = 0;
      held = 0;
   endtask

   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         in_len_reg <= 9'd256;
         out_len_reg <= 7'd64;
         frame_sum = 0;
         held = 0;
         failures <= 0;
         expected_points.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_OUT_LEN) out_len_reg <= pwdata[OUTLEN_W-1:0];
            else in_len_reg <= pwdata[INLEN_W-1:0];
         end
         if (req_valid && !req_stall) begin
            if (held >= IN_MAX_DEFAULT) held = IN_MAX_DEFAULT - 1;
            frame_samples[held] = req_sample;
            frame_sum += req_sample;
            held++;
            if (held >= clamp_len(in_len_reg, IN_MAX_DEFAULT)) decimate_frame(held);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("unexpected transaction x=%0d y=%0d", rsp_x_position, rsp_y_value);
               failures <= failures + 1;
            end else begin
               want = expected_points.pop_front();
               if (want.x !== rsp_x_position) begin
                  $error("x_position expected %0d actual %0d", want.x, rsp_x_position);
                  failures <= failures + 1;
               end else if (want.y !== rsp_y_value) begin
                  $error("y_value expected %0d actual %0d", want.y, rsp_y_value);
                  failures <= failures + 1;
               end else if (want.last !== rsp_last_point) begin
                  $error("last_point expected %0d actual %0d", want.last, rsp_last_point);
                  failures <= failures + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

[tb/peak_preserving_decimator_top_test.sv]
// testbench top: drives samples and register writes, applies idling, reports the verdict
`default_nettype none
module peak_preserving_decimator_top_test import ppd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0, rsp_last_point;
   logic [SAMPLE_W-1:0] req_sample = 0, rsp_y_value;
   logic [XPOS_W-1:0] rsp_x_position;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   int failures, pending, send_idle = 0, recv_idle = 0, quiet = 0;
   bit hold_off = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   peak_preserving_decimator_top dut (.*);
   peak_preserving_decimator_checker scoreboard (.*);

   always @(posedge clock) begin
      if (reset || hold_off) rsp_stall <= hold_off;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 100000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic write_reg(logic [0:0] index, int unsigned value);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= {index, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send_sample(logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic random_frames(int frames);
      int n, kind;
      logic [SAMPLE_W-1:0] v;
      for (int f = 0; f < frames; f++) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 256) : $urandom_range(3, 16);
         write_reg(REG_IN_LEN, n);
         write_reg(REG_OUT_LEN, ($urandom_range(4) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 64));
         kind = $urandom_range(2);
         for (int i = 0; i < n; i++) begin
            if (kind == 0) v = SAMPLE_W'($urandom);
            else if (kind == 1) v = (i % 3 == 1) ? SAMPLE_W'($urandom_range(40000, 65535))
                                                 : SAMPLE_W'($urandom_range(0, 1000));
            else v = SAMPLE_W'($urandom_range(0, 3) * 32'h5555);
            send_sample(v);
         end
         drain();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, ties, plateau peaks, collisions
      write_reg(REG_IN_LEN, 3);
      write_reg(REG_OUT_LEN, 1);
      send_sample(0); send_sample(16'hFFFF); send_sample(0);
      drain();
      write_reg(REG_OUT_LEN, 64);
      send_sample(5); send_sample(5); send_sample(5);
      drain();
      write_reg(REG_IN_LEN, 8);
      write_reg(REG_OUT_LEN, 3);
      send_sample(1); send_sample(9); send_sample(9); send_sample(1);
      send_sample(8); send_sample(1); send_sample(16'hFFFF); send_sample(16'hFFFF);
      drain();
      write_reg(REG_IN_LEN, 0);
      write_reg(REG_OUT_LEN, 0);
      send_sample(16'hAAAA);
      drain();
      write_reg(REG_IN_LEN, 511);
      write_reg(REG_OUT_LEN, 127);
      send_sample(16'h5555);
      send_sample(100);
      drain();
      write_reg(REG_IN_LEN, 2);
      send_sample(7);
      drain();
      // pressure: receiver holds off while a frame completes and more samples queue up
      write_reg(REG_IN_LEN, 4);
      write_reg(REG_OUT_LEN, 64);
      hold_off = 1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 8; i++) send_sample(SAMPLE_W'($urandom));
      join
      drain();
      send_idle = 35; recv_idle = 48;
      random_frames(6);
      send_idle = 48; recv_idle = 35;
      random_frames(6);
      send_idle = 0; recv_idle = 0;
      random_frames(6);
      drain();
      if (failures == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire

[peak_preserving_decimator_top.f]
rtl/ppd_pkg.sv
rtl/ppd_ram.sv
rtl/ppd_front.sv
rtl/ppd_back.sv
rtl/ppd_queue.sv
rtl/peak_preserving_decimator_top.sv
tb/peak_preserving_decimator_checker.sv
tb/peak_preserving_decimator_top_test.sv
